// ===== hdl/wsps_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared types and constants for the pattern search cells and top level.
// ----------------------------------------------------------------------------
package wsps_pkg;

  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int LEN_W        = 5;
  localparam int MASK_W       = 16;
  localparam int PATTERN_W    = 128;
  localparam int OUT_OFFSET_W = 32;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_SHORT = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 4'd0,
    REG_PATTERN_HIGH   = 4'd1,
    REG_WILDCARD_MASK  = 4'd2,
    REG_PATTERN_LENGTH = 4'd3
  } cfg_reg_t;

  // Per-beat control shared by every cell of the chain.
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/wsps_cell.sv =====
// ----------------------------------------------------------------------------
// Pattern search cell
// Holds one bit of the partial match vector and compares one pattern entry.
// ----------------------------------------------------------------------------
module wsps_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]           entry_byte,
  input  logic                 wild,
  input  logic                 enable,
  input  logic [7:0]           data_byte,
  input  logic                 prev_bit,
  output logic                 match_bit,
  output logic                 match_nxt
);

  logic match_r;
  logic entry_eq;

  assign entry_eq  = enable & (wild | (entry_byte == data_byte));
  assign match_nxt = prev_bit & entry_eq;
  assign match_bit = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.advance) begin
      match_r <= match_nxt;
    end
  end

endmodule

// ===== hdl/wildcard_byte_pattern_search.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Streams region bytes through a row of match cells and reports the first
// offset where the configured wildcard pattern matches.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake         Payload
//   in_      input      valid / stall     data_byte[7:0], last_byte
//   out_     output     valid / stall     status[1:0], match_offset[31:0]
//   cfg_     input      valid / ready     index[3:0], data[63:0]
//
// One beat is accepted per cycle while in_stall is low; every cell updates its
// match bit in the cycle the byte is accepted.
// A result is loaded into the output register at the edge that takes its byte.
// Input stall is raised only while a result is held and the output is stalled.
// Reset is synchronous and clears the match vector, offset counter and output valid.
// Configuration writes are always ready.
module wildcard_byte_pattern_search #(
  parameter int PATTERN_MAX  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_last_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic [wsps_pkg::OUT_OFFSET_W-1:0]    out_match_offset,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wsps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wsps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LW = wsps_pkg::LEN_W;

  // Configuration registers.
  logic [wsps_pkg::CFG_DATA_W-1:0] pattern_low_r;
  logic [wsps_pkg::CFG_DATA_W-1:0] pattern_high_r;
  logic [wsps_pkg::MASK_W-1:0]     wildcard_mask_r;
  logic [LW-1:0]                   pattern_length_r;

  // Region state.
  logic [OFFSET_WIDTH-1:0]         bytes_seen_r;
  logic [OFFSET_WIDTH-1:0]         bytes_seen_nxt;
  logic                            reported_r;
  logic                            reported_nxt;

  // Output register.
  logic                            out_valid_r;
  wsps_pkg::status_t               out_status_r;
  wsps_pkg::status_t               out_status_nxt;
  logic [wsps_pkg::OUT_OFFSET_W-1:0] out_offset_r;
  logic [wsps_pkg::OUT_OFFSET_W-1:0] out_offset_nxt;

  logic                            in_accept;
  logic                            result_load;
  logic [wsps_pkg::PATTERN_W-1:0]  pattern_all;
  logic [LW-1:0]                   len_used;
  logic [LW-1:0]                   len_m1;
  logic [OFFSET_WIDTH-1:0]         len_m1_ext;
  logic [OFFSET_WIDTH-1:0]         start_offset;
  logic                            region_short;
  logic                            found;
  logic [PATTERN_MAX-1:0]          match_vec;
  logic [PATTERN_MAX-1:0]          match_vec_nxt;
  logic [PATTERN_MAX-1:0]          len_sel;
  wsps_pkg::cell_ctrl_t            cell_ctrl;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign cell_ctrl.advance = in_accept;
  assign cell_ctrl.clear   = in_accept & in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      wildcard_mask_r  <= '0;
      pattern_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsps_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        wsps_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        wsps_pkg::REG_WILDCARD_MASK:  wildcard_mask_r  <= cfg_data[wsps_pkg::MASK_W-1:0];
        wsps_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_all = {pattern_high_r, pattern_low_r};
  assign len_used    = (pattern_length_r > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
                                                             : pattern_length_r;
  assign len_m1      = len_used - LW'(1);
  assign len_m1_ext  = {{(OFFSET_WIDTH-LW){1'b0}}, len_m1};

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic prev_bit;
      if (gi == 0) begin : g_head
        assign prev_bit = 1'b1;
      end else begin : g_link
        assign prev_bit = match_vec[gi-1];
      end

      assign len_sel[gi] = (len_used == LW'(gi + 1));

      wsps_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl),
        .entry_byte (pattern_all[8*gi +: 8]),
        .wild       (wildcard_mask_r[gi]),
        .enable     (LW'(gi) < len_used),
        .data_byte  (in_data_byte),
        .prev_bit   (prev_bit),
        .match_bit  (match_vec[gi]),
        .match_nxt  (match_vec_nxt[gi])
      );
    end
  endgenerate

  // The newest bit of the vector at the pattern's last entry marks a full match.
  assign found        = ~reported_r & (|(match_vec_nxt & len_sel));
  assign region_short = (len_used != '0) & (bytes_seen_r < len_m1_ext);
  assign start_offset = region_short ? '0 : (bytes_seen_r - len_m1_ext);

  always_comb begin
    out_status_nxt = wsps_pkg::ST_NOT_FOUND;
    out_offset_nxt = '0;
    result_load    = 1'b0;
    if (found) begin
      out_status_nxt = wsps_pkg::ST_FOUND;
      out_offset_nxt = wsps_pkg::OUT_OFFSET_W'(start_offset);
      result_load    = in_accept;
    end else if (in_last_byte && !reported_r) begin
      out_status_nxt = region_short ? wsps_pkg::ST_TOO_SHORT : wsps_pkg::ST_NOT_FOUND;
      result_load    = in_accept;
    end
  end

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (in_accept) begin
      if (in_last_byte) begin
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
      end else begin
        if (bytes_seen_r != '1) begin
          bytes_seen_nxt = bytes_seen_r + OFFSET_WIDTH'(1);
        end
        reported_nxt = reported_r | found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_status_r <= out_status_nxt;
      out_offset_r <= out_offset_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_offset = out_offset_r;

  // A held result that is not a match never carries an offset.
  a_offset_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != wsps_pkg::ST_FOUND) |-> out_offset_r == '0)
    else $error("non-match result carries an offset");

  // The end of a region returns the offset counter, flag and vector to zero.
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_last_byte |=> (bytes_seen_r == '0) && !reported_r && (match_vec == '0))
    else $error("region state not cleared after the last beat");

  // A match in mid-region silences the block until the region ends.
  a_found_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_last_byte && found |=> reported_r)
    else $error("match not recorded");

  // Input is held back only while a result waits downstream.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with an empty output register");

  // A reported region produces no further results until it ends.
  a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> !result_load)
    else $error("result produced after a match was reported");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wildcard byte pattern search testbench
// Drives byte regions through the search block and checks every result.
// A directed script comes first, followed by random phases that embed the
// pattern in noisy regions. Each phase uses its own register setting and runs
// under bursty input traffic and a changing output stall pattern.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 1200;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 4;

  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_HEAVY    = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct packed {
    wsps_pkg::status_t status;
    logic [31:0]       offset;
  } search_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [63:0]       low;
    logic [63:0]       high;
    logic [15:0]       mask;
    logic [4:0]        len;
    logic [7:0]        data;
    logic              last;
    logic              typed;
    wsps_pkg::status_t status;
    logic [31:0]       offset;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_match_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [wsps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wsps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Typed expectation that travels with the beat it belongs to.
  logic              note_typed = 1'b0;
  wsps_pkg::status_t note_status = wsps_pkg::ST_NOT_FOUND;
  logic [31:0]       note_offset = '0;

  wildcard_byte_pattern_search DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_match_offset (out_match_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Search state mirrored from the block's behavior.
  logic [127:0] pat_bytes = '0;
  logic [15:0]  wild_bits = '0;
  logic [4:0]   pat_len = '0;
  logic [15:0]  match_vec = '0;
  logic [31:0]  offset_next = '0;
  logic         found_flag = 1'b0;

  search_result_t pending_results[$];
  int             err_count = 0;
  int             quiet_cycles = 0;
  logic           scan_hit;
  search_result_t scan_res;
  search_result_t want;
  logic           moved;

  task automatic apply_reg(input logic [wsps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] d);
    case (wsps_pkg::cfg_reg_t'(idx))
      wsps_pkg::REG_PATTERN_LOW:    pat_bytes[63:0] = d;
      wsps_pkg::REG_PATTERN_HIGH:   pat_bytes[127:64] = d;
      wsps_pkg::REG_WILDCARD_MASK:  wild_bits = d[15:0];
      wsps_pkg::REG_PATTERN_LENGTH: pat_len = d[4:0];
      default: ;
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic l, output logic hit,
                           output search_result_t r);
    int          n;
    logic [15:0] eq;
    n = (pat_len > 16) ? 16 : pat_len;
    eq = '0;
    hit = 1'b0;
    r.status = wsps_pkg::ST_NOT_FOUND;
    r.offset = '0;
    for (int i = 0; i < n; i++)
      if (wild_bits[i] || pat_bytes[8*i +: 8] == b) eq[i] = 1'b1;
    match_vec = ((match_vec << 1) | 16'd1) & eq;
    if (n > 0 && !found_flag && match_vec[n-1]) begin
      hit = 1'b1;
      r.status = wsps_pkg::ST_FOUND;
      r.offset = (offset_next >= n - 1) ? offset_next - (n - 1) : '0;
      found_flag = 1'b1;
    end
    if (l) begin
      if (!found_flag) begin
        hit = 1'b1;
        r.offset = '0;
        r.status = (n > 0 && offset_next < n - 1) ? wsps_pkg::ST_TOO_SHORT
                                                  : wsps_pkg::ST_NOT_FOUND;
      end
      match_vec = '0;
      offset_next = '0;
      found_flag = 1'b0;
    end else if (offset_next != '1) begin
      offset_next = offset_next + 1;
    end
  endtask

  // Predict on every accepted input beat, then check every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_last_byte, scan_hit, scan_res);
        if (note_typed) begin
          scan_res.status = note_status;
          scan_res.offset = note_offset;
          scan_hit = 1'b1;
        end
        if (scan_hit) pending_results.push_back(scan_res);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual status %0d offset %0d",
                   $time, out_status, out_match_offset);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_match_offset !== want.offset) begin
            err_count++;
            $display("%0t: offset mismatch, expected %0d, actual %0d",
                     $time, want.offset, out_match_offset);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Output stall: a rotating set of patterns plus long holds on request.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // Stimulus side.
  logic [127:0] cur_pattern = '0;
  logic [15:0]  cur_mask = '0;
  logic [4:0]   cur_len = '0;
  int           burst_left = 0;
  int           random_beats = 0;
  script_row_t  script[$];

  task automatic send_beat(input logic [7:0] b, input logic l, input logic typed,
                           input wsps_pkg::status_t st, input logic [31:0] off);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
        in_last_byte <= 1'($urandom);
        @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    note_typed <= typed;
    note_status <= st;
    note_offset <= off;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input wsps_pkg::cfg_reg_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [63:0] low, input logic [63:0] high,
                              input logic [63:0] mask_word, input logic [63:0] len_word);
    wait_for_results();
    write_reg(wsps_pkg::REG_PATTERN_LOW, low);
    write_reg(wsps_pkg::REG_PATTERN_HIGH, high);
    write_reg(wsps_pkg::REG_WILDCARD_MASK, mask_word);
    write_reg(wsps_pkg::REG_PATTERN_LENGTH, len_word);
    cfg_valid <= 1'b0;
    cur_pattern = {high, low};
    cur_mask = mask_word[15:0];
    cur_len = len_word[4:0];
  endtask

  function automatic int used_len();
    return (cur_len > 16) ? 16 : cur_len;
  endfunction

  // A pattern entry as it may appear in the stream: wildcards take any byte.
  function automatic logic [7:0] entry_byte(input int i);
    if (cur_mask[i]) return 8'($urandom);
    return cur_pattern[8*i +: 8];
  endfunction

  // Noise biased toward pattern bytes so that partial matches start often.
  function automatic logic [7:0] filler_byte();
    int n;
    n = used_len();
    if (n > 0 && $urandom_range(0, 1) == 0) return entry_byte($urandom_range(0, n - 1));
    return 8'($urandom);
  endfunction

  task automatic send_region();
    int         n;
    int         kind;
    int         pre;
    int         cut;
    logic [7:0] region[$];
    n = used_len();
    kind = $urandom_range(0, 99);
    if (kind < 60 && n > 0) begin
      pre = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
      cut = ($urandom_range(0, 2) == 0 && n > 1) ? $urandom_range(1, n - 1) : 0;
      repeat (pre) region.push_back(filler_byte());
      // A broken prefix ahead of the real match exercises the shifted vector.
      for (int i = 0; i < cut; i++) region.push_back(entry_byte(i));
      if (cut > 0) region.push_back(8'($urandom));
      for (int i = 0; i < n; i++) region.push_back(entry_byte(i));
      repeat ($urandom_range(0, 6)) region.push_back(filler_byte());
    end else if (kind < 80 || n <= 1) begin
      repeat ($urandom_range(1, 30)) region.push_back(filler_byte());
    end else begin
      for (int i = 0; i < $urandom_range(1, n - 1); i++) region.push_back(entry_byte(i));
    end
    if (region.size() == 0) region.push_back(8'($urandom));
    foreach (region[k])
      send_beat(region[k], k == region.size() - 1, 1'b0, wsps_pkg::ST_NOT_FOUND, '0);
    random_beats += region.size();
  endtask

  function automatic void row_beat(input logic [7:0] d, input logic l);
    script_row_t r;
    r = '0;
    r.data = d;
    r.last = l;
    r.status = wsps_pkg::ST_NOT_FOUND;
    script.push_back(r);
  endfunction

  function automatic void row_result(input logic [7:0] d, input logic l,
                                     input wsps_pkg::status_t st,
                                     input logic [31:0] off);
    script_row_t r;
    r = '0;
    r.data = d;
    r.last = l;
    r.typed = 1'b1;
    r.status = st;
    r.offset = off;
    script.push_back(r);
  endfunction

  function automatic void row_cfg(input logic [63:0] low, input logic [63:0] high,
                                  input logic [15:0] mask, input logic [4:0] len);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.low = low;
    r.high = high;
    r.mask = mask;
    r.len = len;
    r.status = wsps_pkg::ST_NOT_FOUND;
    script.push_back(r);
  endfunction

  initial begin : stimulus
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] mask_word;
    logic [63:0] len_word;
    int          phase_goal;

    // Empty pattern straight after reset.
    row_result(8'h00, 1'b1, wsps_pkg::ST_NOT_FOUND, 32'd0);
    row_result(8'hFF, 1'b1, wsps_pkg::ST_NOT_FOUND, 32'd0);
    // Four-byte pattern: short region, match inside, match on the final byte.
    row_cfg(64'h0000_0000_EFBE_ADDE, 64'd0, 16'h0000, 5'd4);
    row_beat(8'hDE, 1'b0);
    row_result(8'hAD, 1'b1, wsps_pkg::ST_TOO_SHORT, 32'd0);
    row_beat(8'h11, 1'b0);
    row_beat(8'hDE, 1'b0);
    row_beat(8'hAD, 1'b0);
    row_beat(8'hBE, 1'b0);
    row_beat(8'hEF, 1'b0);
    row_beat(8'h22, 1'b1);
    row_beat(8'hDE, 1'b0);
    row_beat(8'hAD, 1'b0);
    row_beat(8'hBE, 1'b0);
    row_result(8'hEF, 1'b1, wsps_pkg::ST_FOUND, 32'd0);
    // Wildcards in the middle of the pattern.
    row_cfg(64'h0000_0000_EFBE_ADDE, 64'd0, 16'h0006, 5'd4);
    row_beat(8'hDE, 1'b0);
    row_beat(8'h00, 1'b0);
    row_beat(8'hFF, 1'b0);
    row_beat(8'hEF, 1'b1);
    // All-ones pattern registers.
    row_cfg('1, '1, 16'h0000, 5'd2);
    row_beat(8'hFF, 1'b0);
    row_beat(8'h7E, 1'b0);
    row_beat(8'hFF, 1'b0);
    row_result(8'hFF, 1'b1, wsps_pkg::ST_FOUND, 32'd2);
    row_cfg(64'd0, 64'd0, 16'h0001, 5'd1);
    row_result(8'hA5, 1'b1, wsps_pkg::ST_FOUND, 32'd0);
    // A zero length never matches, even with every entry a wildcard.
    row_cfg(64'd0, 64'd0, 16'hFFFF, 5'd0);
    row_result(8'h5A, 1'b1, wsps_pkg::ST_NOT_FOUND, 32'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      if (script[k].is_cfg)
        program_regs(script[k].low, script[k].high, 64'(script[k].mask), 64'(script[k].len));
      else
        send_beat(script[k].data, script[k].last, script[k].typed, script[k].status,
                  script[k].offset);
    end

    // Every one-byte region matches; the long hold makes the block back up.
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, 64'h1, 64'h1);
    hold_asks++;
    repeat (40) send_beat(8'($urandom), 1'b1, 1'b0, wsps_pkg::ST_NOT_FOUND, '0);
    wait_for_results();

    while (random_beats < RANDOM_BEATS) begin
      low = {$urandom, $urandom};
      high = {$urandom, $urandom};
      mask_word = {$urandom, $urandom};
      len_word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: begin
          low = '0;
          high = '0;
          mask_word[15:0] = '0;
          len_word[4:0] = 5'd0;
        end
        1: begin
          low = '1;
          high = '1;
          mask_word[15:0] = '0;
          len_word[4:0] = 5'd16;
        end
        2: begin
          mask_word[15:0] = 16'hFFFF;
          len_word[4:0] = 5'd16;
        end
        3: len_word[4:0] = 5'($urandom_range(17, 31));
        4: begin
          mask_word[15:0] = 16'($urandom & $urandom);
          len_word[4:0] = 5'd16;
        end
        default: begin
          mask_word[15:0] = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'($urandom & $urandom);
          len_word[4:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(7, 16))
                                                      : 5'($urandom_range(1, 6));
        end
      endcase
      program_regs(low, high, mask_word, len_word);
      phase_goal = random_beats + $urandom_range(30, 120);
      while (random_beats < phase_goal) send_region();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
